// ===== src/fapr_pkg.sv =====
// shared types, constants and decode helpers for the framed packet receiver
package fapr_pkg;

	localparam int FRAME_LEN = 6;
	localparam int CNT_W = $clog2(FRAME_LEN + 1);
	localparam int AXIS_W = 14;
	localparam int WORD_W = 16;
	localparam int SCALE_SHIFT = 12;
	localparam int MUL_SHIFT = 10;

	localparam logic [7:0] START_MARKER_RST = 8'h53;
	localparam logic [7:0] STOP_MARKER_RST = 8'h52;

	typedef logic [7:0] data_byte_t;

	typedef enum logic {
		CFG_START_MARKER = 1'b0,
		CFG_STOP_MARKER = 1'b1
	} cfg_index_t;

	typedef struct packed {
		logic [AXIS_W-1:0] axis_x;
		logic [AXIS_W-1:0] axis_y;
		logic [WORD_W-1:0] button_bits;
	} result_t;

	// v * 1023 / 4096 as (v << 10) - v, then drop the low 12 bits
	function automatic logic [AXIS_W-1:0] scale_axis(input logic [WORD_W-1:0] v);
		logic [WORD_W+MUL_SHIFT-1:0] p;
		p = {v, MUL_SHIFT'(0)} - {MUL_SHIFT'(0), v};
		return p[WORD_W+MUL_SHIFT-1:SCALE_SHIFT];
	endfunction

endpackage

// ===== src/fapr_cell.sv =====
// one byte cell of the frame shift chain
module fapr_cell (
	input  logic                clk,
	input  logic                shift_en,
	input  fapr_pkg::data_byte_t d_in,
	output fapr_pkg::data_byte_t d_out
);

	fapr_pkg::data_byte_t data_q;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			data_q <= d_in;
		end
	end

	assign d_out = data_q;

endmodule

// ===== src/fapr_decode.sv =====
// frame decode: three little-endian words from the cell chain, two of them scaled
module fapr_decode (
	input  fapr_pkg::data_byte_t cells [fapr_pkg::FRAME_LEN],
	output fapr_pkg::result_t    res
);

	localparam int L = fapr_pkg::FRAME_LEN;

	// oldest byte sits in the last cell, so frame byte k is cell L-1-k
	logic [fapr_pkg::WORD_W-1:0] word0;
	logic [fapr_pkg::WORD_W-1:0] word1;
	logic [fapr_pkg::WORD_W-1:0] word2;

	assign word0 = {cells[L-2], cells[L-1]};
	assign word1 = {cells[L-4], cells[L-3]};
	assign word2 = {cells[L-6], cells[L-5]};

	always_comb begin
		res.axis_x = fapr_pkg::scale_axis(word0);
		res.axis_y = fapr_pkg::scale_axis(word1);
		res.button_bits = word2;
	end

endmodule

// ===== src/framed_axis_packet_receiver_unit.sv =====
// top level of the start/stop byte framed packet receiver
// Takes one received byte per cycle through in_valid/in_ready. Bytes are kept in a chain of six
// byte cells that shifts on every stored byte; a stop byte after six stored bytes decodes the frame
// and the result appears on the output register in the next cycle. Input is held off only when the
// frame is full and the previous result is still waiting for out_ready, which the stop-byte rule of
// the next decode would otherwise overrun. Marker registers are written through cfg_valid/cfg_index/
// cfg_data and are always ready.
module framed_axis_packet_receiver_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  fapr_pkg::cfg_index_t               cfg_index,
	input  logic [7:0]                         cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [7:0]                         rx_byte,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [fapr_pkg::AXIS_W-1:0]        axis_x,
	output logic [fapr_pkg::AXIS_W-1:0]        axis_y,
	output logic [fapr_pkg::WORD_W-1:0]        button_bits
);

	localparam int L = fapr_pkg::FRAME_LEN;

	fapr_pkg::data_byte_t start_q;
	fapr_pkg::data_byte_t stop_q;
	logic                 open_q;
	logic [fapr_pkg::CNT_W-1:0] count_q;
	logic                 out_valid_q;
	fapr_pkg::result_t    res_q;

	fapr_pkg::data_byte_t cells [L];
	fapr_pkg::result_t    dec_res;

	logic full;
	logic is_start;
	logic is_stop;
	logic req_acc;
	logic store_en;
	logic decode;

	assign full = count_q == fapr_pkg::CNT_W'(L);
	assign is_start = (rx_byte == start_q) && !open_q;
	assign is_stop = (rx_byte == stop_q) && full;
	assign in_ready = !(out_valid_q && !out_ready && full);
	assign req_acc = in_valid && in_ready;
	assign store_en = req_acc && !is_start && !full;
	assign decode = req_acc && !is_start && is_stop;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= fapr_pkg::START_MARKER_RST;
			stop_q <= fapr_pkg::STOP_MARKER_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				fapr_pkg::CFG_START_MARKER: start_q <= cfg_data;
				fapr_pkg::CFG_STOP_MARKER: stop_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			count_q <= '0;
		end else if (req_acc) begin
			if (is_start) begin
				open_q <= 1'b1;
				count_q <= '0;
			end else if (full) begin
				open_q <= 1'b0;
				count_q <= '0;
			end else begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// byte chain: new byte enters cell 0, older bytes move one cell along
	genvar gi;
	generate
		for (gi = 0; gi < L; gi++) begin : g_cell
			if (gi == 0) begin : g_head
				fapr_cell u_cell (
					.clk     (clk),
					.shift_en(store_en),
					.d_in    (rx_byte),
					.d_out   (cells[gi])
				);
			end else begin : g_body
				fapr_cell u_cell (
					.clk     (clk),
					.shift_en(store_en),
					.d_in    (cells[gi-1]),
					.d_out   (cells[gi])
				);
			end
		end
	endgenerate

	fapr_decode u_decode (
		.cells(cells),
		.res  (dec_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (decode) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (decode) begin
			res_q <= dec_res;
		end
	end

	assign out_valid = out_valid_q;
	assign axis_x = res_q.axis_x;
	assign axis_y = res_q.axis_y;
	assign button_bits = res_q.button_bits;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= fapr_pkg::CNT_W'(L))
		else $error("byte count beyond frame length");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !decode)
		else $error("decode while result still pending");

	a_decode_out: assert property (@(posedge clk) disable iff (!arst_n)
		decode |=> (out_valid_q && count_q == '0 && !open_q))
		else $error("decode did not present result and close frame");

	a_start_opens: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && is_start) |=> (open_q && count_q == '0))
		else $error("start byte did not open frame");

endmodule
